@@ sv/vvpu_pkg.sv @@
// ----------------------------------------------------------------------------
// Velocity Verlet particle update package
// Shared widths, register codes, reset values and fixed-point helpers.
// ----------------------------------------------------------------------------
package vvpu_pkg;

    // Value format: signed Q16.16 for positions, velocities, forces.
    localparam int VALUE_W    = 32;
    localparam int STEP_W     = 32;
    localparam int INV_W      = 31;
    localparam int DT_W       = STEP_W + INV_W;
    localparam int PROD_W     = 64;
    localparam int SUM_W      = 48;
    localparam int KICK_W     = 46;
    localparam int KICK_SHIFT = 49;
    localparam int KICK_LSB   = KICK_SHIFT - 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y_HIGH = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0]         RST_STEP_SIZE = 32'd42950;
    localparam logic signed [VALUE_W-1:0] RST_BOX_LOW   = 32'sd0;
    localparam logic signed [VALUE_W-1:0] RST_BOX_HIGH  = 32'sd65536;

    // Two pi in Q16.16.
    localparam logic signed [VALUE_W-1:0] TWO_PI = 32'sd411775;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Saturate a wide signed sum to the value range.
    function automatic logic signed [VALUE_W-1:0] sat_value(
        input logic signed [SUM_W-1:0] x
    );
        logic all_zero;
        logic all_one;
        all_zero = ~|x[SUM_W-2:VALUE_W-1];
        all_one  = &x[SUM_W-2:VALUE_W-1];
        if (!x[SUM_W-1] && !all_zero) begin
            return VALUE_MAX;
        end else if (x[SUM_W-1] && !all_one) begin
            return VALUE_MIN;
        end else begin
            return x[VALUE_W-1:0];
        end
    endfunction

    // Magnitude of a signed value; the most negative value maps to 2^(W-1).
    function automatic logic [VALUE_W-1:0] abs_mag(
        input logic signed [VALUE_W-1:0] v
    );
        logic [VALUE_W-1:0] u;
        u = v;
        return v[VALUE_W-1] ? (~u + VALUE_W'(1)) : u;
    endfunction

    // Sign extension of a value to the sum width.
    function automatic logic signed [SUM_W-1:0] ext_value(
        input logic signed [VALUE_W-1:0] v
    );
        return {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
    endfunction

endpackage

@@ sv/vvpu_kick.sv @@
// ----------------------------------------------------------------------------
// Half kick lane
// Four-stage pipeline: v' = sat(v + step * inv * force / 2^49), with the
// kick magnitude truncated toward zero and carrying the sign of the force.
// ----------------------------------------------------------------------------
module vvpu_kick (
    input  logic                                  i_clk,
    input  logic [vvpu_pkg::STEP_W-1:0]           i_step,
    input  logic [vvpu_pkg::INV_W-1:0]            i_inv,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]   i_force,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]   i_vel,
    output logic signed [vvpu_pkg::VALUE_W-1:0]   o_vel
);

    // Stage A: step times inverse mass, force magnitude.
    logic [vvpu_pkg::DT_W-1:0]           r_a_dt;
    logic [vvpu_pkg::VALUE_W-1:0]        r_a_mag;
    logic                                r_a_neg;
    logic signed [vvpu_pkg::VALUE_W-1:0] r_a_vel;
    logic [vvpu_pkg::DT_W-1:0]           n_a_dt;

    assign n_a_dt = {{vvpu_pkg::INV_W{1'b0}}, i_step}
                  * {{vvpu_pkg::STEP_W{1'b0}}, i_inv};

    always_ff @(posedge i_clk) begin
        r_a_dt  <= n_a_dt;
        r_a_mag <= vvpu_pkg::abs_mag(i_force);
        r_a_neg <= i_force[vvpu_pkg::VALUE_W-1];
        r_a_vel <= i_vel;
    end

    // Stage B: two partial products of the 63 by 32 bit product.
    logic [vvpu_pkg::PROD_W-1:0]         r_b_pp_lo;
    logic [vvpu_pkg::PROD_W-1:0]         r_b_pp_hi;
    logic                                r_b_neg;
    logic signed [vvpu_pkg::VALUE_W-1:0] r_b_vel;
    logic [vvpu_pkg::PROD_W-1:0]         n_b_pp_lo;
    logic [vvpu_pkg::PROD_W-1:0]         n_b_pp_hi;

    assign n_b_pp_lo = {32'd0, r_a_dt[31:0]} * {32'd0, r_a_mag};
    assign n_b_pp_hi = {33'd0, r_a_dt[vvpu_pkg::DT_W-1:32]} * {32'd0, r_a_mag};

    always_ff @(posedge i_clk) begin
        r_b_pp_lo <= n_b_pp_lo;
        r_b_pp_hi <= n_b_pp_hi;
        r_b_neg   <= r_a_neg;
        r_b_vel   <= r_a_vel;
    end

    // Stage C: combine partial products and drop the fraction bits.
    logic [vvpu_pkg::KICK_W-1:0]         r_c_kick;
    logic                                r_c_neg;
    logic signed [vvpu_pkg::VALUE_W-1:0] r_c_vel;
    logic [vvpu_pkg::PROD_W-1:0]         n_c_sum;

    assign n_c_sum = r_b_pp_hi + {32'd0, r_b_pp_lo[vvpu_pkg::PROD_W-1:32]};

    always_ff @(posedge i_clk) begin
        r_c_kick <= n_c_sum[vvpu_pkg::KICK_LSB+vvpu_pkg::KICK_W-1:vvpu_pkg::KICK_LSB];
        r_c_neg  <= r_b_neg;
        r_c_vel  <= r_b_vel;
    end

    // Stage D: signed add and saturation.
    logic signed [vvpu_pkg::SUM_W-1:0]   n_d_kick;
    logic signed [vvpu_pkg::SUM_W-1:0]   n_d_sum;
    logic signed [vvpu_pkg::VALUE_W-1:0] r_d_vel;

    always_comb begin
        n_d_kick = {{(vvpu_pkg::SUM_W-vvpu_pkg::KICK_W){1'b0}}, r_c_kick};
        if (r_c_neg) begin
            n_d_kick = -n_d_kick;
        end
        n_d_sum = vvpu_pkg::ext_value(r_c_vel) + n_d_kick;
    end

    always_ff @(posedge i_clk) begin
        r_d_vel <= vvpu_pkg::sat_value(n_d_sum);
    end

    assign o_vel = r_d_vel;

endmodule

@@ sv/vvpu_drift.sv @@
// ----------------------------------------------------------------------------
// Drift and periodic fold lane
// Three-stage pipeline: p' = sat(p + step * v / 2^32), then one fold into
// [low, high) when wrapping is on. Positions pass unchanged when drift is off.
// ----------------------------------------------------------------------------
module vvpu_drift (
    input  logic                                  i_clk,
    input  logic [vvpu_pkg::STEP_W-1:0]           i_step,
    input  logic                                  i_en,
    input  logic                                  i_wrap,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]   i_low,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]   i_high,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]   i_pos,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]   i_vel,
    output logic signed [vvpu_pkg::VALUE_W-1:0]   o_pos
);

    // Stage E: step times velocity magnitude, upper half kept.
    logic [vvpu_pkg::PROD_W-1:0]         n_e_prod;
    logic [vvpu_pkg::VALUE_W-1:0]        r_e_dist;
    logic                                r_e_neg;
    logic                                r_e_en;
    logic signed [vvpu_pkg::VALUE_W-1:0] r_e_pos;

    assign n_e_prod = {32'd0, i_step} * {32'd0, vvpu_pkg::abs_mag(i_vel)};

    always_ff @(posedge i_clk) begin
        r_e_dist <= n_e_prod[vvpu_pkg::PROD_W-1:32];
        r_e_neg  <= i_vel[vvpu_pkg::VALUE_W-1];
        r_e_en   <= i_en;
        r_e_pos  <= i_pos;
    end

    // Stage F: signed add and saturation.
    logic signed [vvpu_pkg::SUM_W-1:0]   n_f_dist;
    logic signed [vvpu_pkg::SUM_W-1:0]   n_f_sum;
    logic signed [vvpu_pkg::VALUE_W-1:0] r_f_pos;
    logic                                r_f_en;

    always_comb begin
        n_f_dist = {{(vvpu_pkg::SUM_W-vvpu_pkg::VALUE_W){1'b0}}, r_e_dist};
        if (r_e_neg) begin
            n_f_dist = -n_f_dist;
        end
        n_f_sum = vvpu_pkg::ext_value(r_e_pos) + n_f_dist;
    end

    always_ff @(posedge i_clk) begin
        r_f_pos <= r_e_en ? vvpu_pkg::sat_value(n_f_sum) : r_e_pos;
        r_f_en  <= r_e_en;
    end

    // Stage G: single periodic fold, saturated.
    logic signed [vvpu_pkg::SUM_W-1:0]   n_g_pos;
    logic signed [vvpu_pkg::SUM_W-1:0]   n_g_low;
    logic signed [vvpu_pkg::SUM_W-1:0]   n_g_high;
    logic signed [vvpu_pkg::SUM_W-1:0]   n_g_span;
    logic signed [vvpu_pkg::VALUE_W-1:0] n_g_fold;
    logic signed [vvpu_pkg::VALUE_W-1:0] r_g_pos;

    always_comb begin
        n_g_pos  = vvpu_pkg::ext_value(r_f_pos);
        n_g_low  = vvpu_pkg::ext_value(i_low);
        n_g_high = vvpu_pkg::ext_value(i_high);
        n_g_span = n_g_high - n_g_low;
        priority if (!(r_f_en && i_wrap)) begin
            n_g_fold = r_f_pos;
        end else if (n_g_pos < n_g_low) begin
            n_g_fold = vvpu_pkg::sat_value(n_g_pos + n_g_span);
        end else if (n_g_pos >= n_g_high) begin
            n_g_fold = vvpu_pkg::sat_value(n_g_pos - n_g_span);
        end else begin
            n_g_fold = r_f_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_pos <= n_g_fold;
    end

    assign o_pos = r_g_pos;

endmodule

@@ sv/velocity_verlet_particle_update.sv @@
// ----------------------------------------------------------------------------
// Velocity Verlet particle update, 2D with rotation
// Fully pipelined half kick, drift and periodic fold of one particle.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high; busy is always low,
//   so one particle can be issued in every cycle.
//   Each result appears on the o_new_* ports for exactly one cycle with
//   o_result_valid high, once its request has passed all the register
//   stages of the pipeline. The
//   pipeline runs a fixed seven register stages: four for the kick (step
//   times inverse mass, split partial products, combine, signed add) and
//   three for the drift (step times velocity, add, fold).
//   Throughput is one particle per cycle; results leave in request order.
//   The receiver cannot stall, so the pipeline never holds.
//   Configuration writes use i_cfg_valid / o_cfg_ready with a register
//   index and data; o_cfg_ready is always high. Writes are registered when
//   taken and should be made while no request is in flight.
//   Synchronous active-low reset clears the valid pipeline and loads the
//   register reset values; no result is produced until a new request.
// ----------------------------------------------------------------------------
module velocity_verlet_particle_update (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Request channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_operation,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]    i_pos_x,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]    i_pos_y,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]    i_angle,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]    i_vel_x,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]    i_vel_y,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]    i_spin,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]    i_force_x,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]    i_force_y,
    input  logic signed [vvpu_pkg::VALUE_W-1:0]    i_torque_in,
    input  logic [vvpu_pkg::INV_W-1:0]             i_inv_mass,
    input  logic [vvpu_pkg::INV_W-1:0]             i_inv_inertia,
    // Result channel
    output logic                                   o_result_valid,
    output logic signed [vvpu_pkg::VALUE_W-1:0]    o_new_pos_x,
    output logic signed [vvpu_pkg::VALUE_W-1:0]    o_new_pos_y,
    output logic signed [vvpu_pkg::VALUE_W-1:0]    o_new_angle,
    output logic signed [vvpu_pkg::VALUE_W-1:0]    o_new_vel_x,
    output logic signed [vvpu_pkg::VALUE_W-1:0]    o_new_vel_y,
    output logic signed [vvpu_pkg::VALUE_W-1:0]    o_new_spin,
    // Configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [vvpu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [vvpu_pkg::VALUE_W-1:0]           i_cfg_data
);

    localparam int KICK_STAGES  = 4;
    localparam int DRIFT_STAGES = 3;
    localparam int PIPE_STAGES  = KICK_STAGES + DRIFT_STAGES;

    // Configuration registers.
    logic [vvpu_pkg::STEP_W-1:0]         r_step_size;
    logic                                r_wrap_x;
    logic                                r_wrap_y;
    logic signed [vvpu_pkg::VALUE_W-1:0] r_box_x_low;
    logic signed [vvpu_pkg::VALUE_W-1:0] r_box_x_high;
    logic signed [vvpu_pkg::VALUE_W-1:0] r_box_y_low;
    logic signed [vvpu_pkg::VALUE_W-1:0] r_box_y_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size  <= vvpu_pkg::RST_STEP_SIZE;
            r_wrap_x     <= 1'b0;
            r_wrap_y     <= 1'b0;
            r_box_x_low  <= vvpu_pkg::RST_BOX_LOW;
            r_box_x_high <= vvpu_pkg::RST_BOX_HIGH;
            r_box_y_low  <= vvpu_pkg::RST_BOX_LOW;
            r_box_y_high <= vvpu_pkg::RST_BOX_HIGH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                vvpu_pkg::CFG_STEP_SIZE:  r_step_size  <= i_cfg_data;
                vvpu_pkg::CFG_WRAP_X:     r_wrap_x     <= i_cfg_data[0];
                vvpu_pkg::CFG_WRAP_Y:     r_wrap_y     <= i_cfg_data[0];
                vvpu_pkg::CFG_BOX_X_LOW:  r_box_x_low  <= i_cfg_data;
                vvpu_pkg::CFG_BOX_X_HIGH: r_box_x_high <= i_cfg_data;
                vvpu_pkg::CFG_BOX_Y_LOW:  r_box_y_low  <= i_cfg_data;
                vvpu_pkg::CFG_BOX_Y_HIGH: r_box_y_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The pipeline never holds, so a request is taken whenever start is high.
    logic w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Valid bits travel alongside the data stages.
    logic [PIPE_STAGES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[PIPE_STAGES-2:0], w_accept};
        end
    end

    assign o_result_valid = r_valid[PIPE_STAGES-1];

    // Half kick lanes.
    logic signed [vvpu_pkg::VALUE_W-1:0] w_kick_vx;
    logic signed [vvpu_pkg::VALUE_W-1:0] w_kick_vy;
    logic signed [vvpu_pkg::VALUE_W-1:0] w_kick_om;

    vvpu_kick u_kick_vx (
        .i_clk   (i_clk),
        .i_step  (r_step_size),
        .i_inv   (i_inv_mass),
        .i_force (i_force_x),
        .i_vel   (i_vel_x),
        .o_vel   (w_kick_vx)
    );

    vvpu_kick u_kick_vy (
        .i_clk   (i_clk),
        .i_step  (r_step_size),
        .i_inv   (i_inv_mass),
        .i_force (i_force_y),
        .i_vel   (i_vel_y),
        .o_vel   (w_kick_vy)
    );

    vvpu_kick u_kick_om (
        .i_clk   (i_clk),
        .i_step  (r_step_size),
        .i_inv   (i_inv_inertia),
        .i_force (i_torque_in),
        .i_vel   (i_spin),
        .o_vel   (w_kick_om)
    );

    // Positions and operation wait while the kick lanes work.
    logic signed [vvpu_pkg::VALUE_W-1:0] r_px_dly [KICK_STAGES];
    logic signed [vvpu_pkg::VALUE_W-1:0] r_py_dly [KICK_STAGES];
    logic signed [vvpu_pkg::VALUE_W-1:0] r_th_dly [KICK_STAGES];
    logic [KICK_STAGES-1:0]              r_drift_dly;

    always_ff @(posedge i_clk) begin
        r_px_dly[0] <= i_pos_x;
        r_py_dly[0] <= i_pos_y;
        r_th_dly[0] <= i_angle;
        for (int i = 1; i < KICK_STAGES; i++) begin
            r_px_dly[i] <= r_px_dly[i-1];
            r_py_dly[i] <= r_py_dly[i-1];
            r_th_dly[i] <= r_th_dly[i-1];
        end
        r_drift_dly <= {r_drift_dly[KICK_STAGES-2:0], ~i_operation};
    end

    // Drift and fold lanes; the angle folds whenever either axis wraps.
    logic w_drift;
    logic w_wrap_any;

    assign w_drift    = r_drift_dly[KICK_STAGES-1];
    assign w_wrap_any = r_wrap_x || r_wrap_y;

    vvpu_drift u_drift_x (
        .i_clk  (i_clk),
        .i_step (r_step_size),
        .i_en   (w_drift),
        .i_wrap (r_wrap_x),
        .i_low  (r_box_x_low),
        .i_high (r_box_x_high),
        .i_pos  (r_px_dly[KICK_STAGES-1]),
        .i_vel  (w_kick_vx),
        .o_pos  (o_new_pos_x)
    );

    vvpu_drift u_drift_y (
        .i_clk  (i_clk),
        .i_step (r_step_size),
        .i_en   (w_drift),
        .i_wrap (r_wrap_y),
        .i_low  (r_box_y_low),
        .i_high (r_box_y_high),
        .i_pos  (r_py_dly[KICK_STAGES-1]),
        .i_vel  (w_kick_vy),
        .o_pos  (o_new_pos_y)
    );

    vvpu_drift u_drift_th (
        .i_clk  (i_clk),
        .i_step (r_step_size),
        .i_en   (w_drift),
        .i_wrap (w_wrap_any),
        .i_low  ('0),
        .i_high (vvpu_pkg::TWO_PI),
        .i_pos  (r_th_dly[KICK_STAGES-1]),
        .i_vel  (w_kick_om),
        .o_pos  (o_new_angle)
    );

    // Kicked velocities wait for the drift lanes.
    logic signed [vvpu_pkg::VALUE_W-1:0] r_vx_dly [DRIFT_STAGES];
    logic signed [vvpu_pkg::VALUE_W-1:0] r_vy_dly [DRIFT_STAGES];
    logic signed [vvpu_pkg::VALUE_W-1:0] r_om_dly [DRIFT_STAGES];

    always_ff @(posedge i_clk) begin
        r_vx_dly[0] <= w_kick_vx;
        r_vy_dly[0] <= w_kick_vy;
        r_om_dly[0] <= w_kick_om;
        for (int i = 1; i < DRIFT_STAGES; i++) begin
            r_vx_dly[i] <= r_vx_dly[i-1];
            r_vy_dly[i] <= r_vy_dly[i-1];
            r_om_dly[i] <= r_om_dly[i-1];
        end
    end

    assign o_new_vel_x = r_vx_dly[DRIFT_STAGES-1];
    assign o_new_vel_y = r_vy_dly[DRIFT_STAGES-1];
    assign o_new_spin  = r_om_dly[DRIFT_STAGES-1];

endmodule
